// File: src/url_glob_matcher_macros.svh
// Assertion macros for the url glob matcher.
// Included by the top level; no other dependencies.
`ifndef URL_GLOB_MATCHER_MACROS_SVH
`define URL_GLOB_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define UGM_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define UGM_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define UGM_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define UGM_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

// File: src/ugm_pkg.sv
// Shared constants, types and codes of the url glob matcher.
// No dependencies; used by ugm_front, ugm_engine and url_glob_matcher.
package ugm_pkg;

  localparam int PATTERN_MAX   = 64;
  localparam int CANDIDATE_MAX = 256;

  localparam int PCW = $clog2(PATTERN_MAX + 1);
  localparam int CCW = $clog2(CANDIDATE_MAX + 1);
  localparam int PAW = $clog2(PATTERN_MAX);
  localparam int CAW = $clog2(CANDIDATE_MAX);
  localparam int LW  = (PCW > CCW) ? PCW : CCW;

  localparam int FQ_DEPTH = 4;
  localparam int FQ_PW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

  typedef logic [PCW-1:0]   pcnt_t;
  typedef logic [CCW-1:0]   ccnt_t;
  typedef logic [PAW-1:0]   paddr_t;
  typedef logic [CAW-1:0]   caddr_t;
  typedef logic [LW-1:0]    len_cmp_t;
  typedef logic [FQ_PW-1:0] fq_ptr_t;
  typedef logic [FQ_CW-1:0] fq_cnt_t;

  // input op codes
  localparam logic [1:0] OP_PATTERN   = 2'd0;
  localparam logic [1:0] OP_CANDIDATE = 2'd1;
  localparam logic [1:0] OP_FINISH    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MATCH_FLAGS = 2'd0;
  localparam logic [1:0] REG_KNOWN_MASK  = 2'd1;

  localparam int FLAG_GLOB = 0;
  localparam logic [1:0] KNOWN_MASK_RESET = 2'd1;

  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  typedef enum logic [1:0] {
    KIND_PATTERN,
    KIND_CANDIDATE,
    KIND_FINISH
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_out_t;

  typedef struct packed {
    logic busy;
    logic ready;
  } eng_status_t;

endpackage

// File: src/ugm_front.sv
// Front end: takes input beats, decodes the op and queues the work items.
// Depends on ugm_pkg.
module ugm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           op,
  input  logic [7:0]           byte_value,
  output ugm_pkg::fq_out_t     fq,
  input  logic                 fq_ready
);

  ugm_pkg::item_t   slots [ugm_pkg::FQ_DEPTH];
  ugm_pkg::fq_ptr_t wr_ptr;
  ugm_pkg::fq_ptr_t rd_ptr;
  ugm_pkg::fq_cnt_t count;
  ugm_pkg::item_t   dec_item;
  logic             dec_valid;
  logic             wr_en;
  logic             rd_en;

  always_comb begin
    dec_item.data = byte_value;
    dec_item.kind = ugm_pkg::KIND_PATTERN;
    dec_valid     = 1'b1;
    case (op)
      ugm_pkg::OP_PATTERN:   dec_item.kind = ugm_pkg::KIND_PATTERN;
      ugm_pkg::OP_CANDIDATE: dec_item.kind = ugm_pkg::KIND_CANDIDATE;
      ugm_pkg::OP_FINISH:    dec_item.kind = ugm_pkg::KIND_FINISH;
      default:               dec_valid = 1'b0;  // unused op: taken, dropped
    endcase
  end

  assign full     = (count == ugm_pkg::fq_cnt_t'(ugm_pkg::FQ_DEPTH));
  assign wr_en    = push && !full && dec_valid;
  assign fq.valid = (count != '0);
  assign fq.item  = slots[rd_ptr];
  assign rd_en    = fq.valid && fq_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= dec_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/ugm_engine.sv
// Back end: string stores, exact and glob match sequencer, result register.
// Depends on ugm_pkg.
module ugm_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  ugm_pkg::fq_out_t      fq,
  output ugm_pkg::eng_status_t  status,
  input  logic [1:0]            flags,
  input  logic [1:0]            known_mask,
  output logic                  empty,
  input  logic                  pop,
  output logic                  matched,
  output logic                  overflow
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_EVAL,
    S_RFETCH,
    S_REVAL,
    S_SPAN,
    S_XFETCH,
    S_XEVAL,
    S_DONE
  } state_t;

  state_t         state;
  logic [7:0]     pmem [ugm_pkg::PATTERN_MAX];
  logic [7:0]     cmem [ugm_pkg::CANDIDATE_MAX];
  logic [7:0]     pa_data;
  logic [7:0]     pb_data;
  logic [7:0]     c_data;

  ugm_pkg::pcnt_t plen;
  ugm_pkg::ccnt_t clen;
  logic           ovf_seen;
  ugm_pkg::pcnt_t pp;
  ugm_pkg::ccnt_t cp;
  logic           seg_v;
  ugm_pkg::pcnt_t seg_pat;
  ugm_pkg::ccnt_t seg_cand;
  logic           span_v;
  ugm_pkg::pcnt_t span_pat;
  ugm_pkg::ccnt_t span_cand;
  logic           star_run;
  logic           star_multi;
  logic           done_match;
  logic           res_valid;
  logic           res_matched;
  logic           res_ovf;

  logic                  take;
  logic                  p_wr;
  logic                  c_wr;
  logic [ugm_pkg::PCW:0] pp_plus1;
  logic                  pat_in;
  logic                  esc_ok;
  logic                  star_here;
  logic [1:0]            span;
  logic                  span_ok;
  logic                  flags_bad;
  ugm_pkg::caddr_t       c_addr;

  assign status.ready = (state == S_IDLE) &&
                        (fq.item.kind != ugm_pkg::KIND_FINISH || !res_valid);
  assign status.busy  = (state != S_IDLE);
  assign take         = fq.valid && status.ready;
  assign p_wr = take && fq.item.kind == ugm_pkg::KIND_PATTERN &&
                plen < ugm_pkg::pcnt_t'(ugm_pkg::PATTERN_MAX);
  assign c_wr = take && fq.item.kind == ugm_pkg::KIND_CANDIDATE &&
                clen < ugm_pkg::ccnt_t'(ugm_pkg::CANDIDATE_MAX);

  assign empty    = !res_valid;
  assign matched  = res_matched;
  assign overflow = res_ovf;

  assign flags_bad = (flags & ~known_mask) != 2'b00;
  assign pp_plus1  = {1'b0, pp} + 1'b1;
  assign pat_in    = pp < plen;
  assign esc_ok    = pp_plus1 < {1'b0, plen};
  assign star_here = pat_in && pa_data == ugm_pkg::CH_STAR;
  assign span_ok   = span_v && span_cand < clen;
  assign c_addr    = (state == S_RFETCH) ? seg_cand[ugm_pkg::CAW-1:0] : cp[ugm_pkg::CAW-1:0];

  // pattern bytes consumed by the element at pp against the candidate byte
  always_comb begin
    if (!pat_in) begin
      span = 2'd0;
    end else if (pa_data == ugm_pkg::CH_QMARK) begin
      span = (c_data != ugm_pkg::CH_SLASH) ? 2'd1 : 2'd0;
    end else if (pa_data == ugm_pkg::CH_BSLASH && esc_ok) begin
      span = (pb_data == c_data) ? 2'd2 : 2'd0;
    end else begin
      span = (pa_data == c_data) ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_wr) begin
      pmem[plen[ugm_pkg::PAW-1:0]] <= fq.item.data;
    end
    pa_data <= pmem[pp[ugm_pkg::PAW-1:0]];
    pb_data <= pmem[pp_plus1[ugm_pkg::PAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (c_wr) begin
      cmem[clen[ugm_pkg::CAW-1:0]] <= fq.item.data;
    end
    c_data <= cmem[c_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      plen      <= '0;
      clen      <= '0;
      ovf_seen  <= 1'b0;
      seg_v     <= 1'b0;
      span_v    <= 1'b0;
      star_run  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            case (fq.item.kind)
              ugm_pkg::KIND_PATTERN: begin
                if (p_wr) plen <= plen + 1'b1;
                else ovf_seen <= 1'b1;
              end
              ugm_pkg::KIND_CANDIDATE: begin
                if (c_wr) clen <= clen + 1'b1;
                else ovf_seen <= 1'b1;
              end
              default: begin
                pp       <= '0;
                cp       <= '0;
                seg_v    <= 1'b0;
                span_v   <= 1'b0;
                star_run <= 1'b0;
                if (ovf_seen || flags_bad) begin
                  done_match <= 1'b0;
                  state      <= S_DONE;
                end else if (flags[ugm_pkg::FLAG_GLOB]) begin
                  state <= S_FETCH;
                end else if (ugm_pkg::len_cmp_t'(plen) != ugm_pkg::len_cmp_t'(clen)) begin
                  done_match <= 1'b0;
                  state      <= S_DONE;
                end else begin
                  state <= S_XFETCH;
                end
              end
            endcase
          end
        end
        S_FETCH: state <= S_EVAL;
        S_EVAL: begin
          if (star_run) begin
            if (star_here) begin
              pp         <= pp + 1'b1;
              star_multi <= 1'b1;
              state      <= S_FETCH;
            end else begin
              // run of stars ended; pp unchanged so the read data stays good
              star_run <= 1'b0;
              if (star_multi) begin
                span_v    <= 1'b1;
                span_pat  <= pp;
                span_cand <= cp;
                seg_v     <= 1'b0;
              end else begin
                seg_v    <= 1'b1;
                seg_pat  <= pp;
                seg_cand <= cp;
              end
            end
          end else if (star_here) begin
            star_run   <= 1'b1;
            star_multi <= 1'b0;
            pp         <= pp + 1'b1;
            state      <= S_FETCH;
          end else if (cp < clen && span != 2'd0) begin
            pp    <= pp + ugm_pkg::pcnt_t'(span);
            cp    <= cp + 1'b1;
            state <= S_FETCH;
          end else if (cp >= clen && pp == plen) begin
            done_match <= 1'b1;
            state      <= S_DONE;
          end else begin
            state <= seg_v ? S_RFETCH : S_SPAN;
          end
        end
        S_RFETCH: state <= S_REVAL;
        S_REVAL: begin
          if (seg_cand < clen && c_data != ugm_pkg::CH_SLASH) begin
            seg_cand <= seg_cand + 1'b1;
            pp       <= seg_pat;
            cp       <= seg_cand + 1'b1;
            state    <= S_FETCH;
          end else begin
            seg_v <= 1'b0;
            state <= S_SPAN;
          end
        end
        S_SPAN: begin
          if (span_ok) begin
            span_cand <= span_cand + 1'b1;
            seg_v     <= 1'b0;
            pp        <= span_pat;
            cp        <= span_cand + 1'b1;
            state     <= S_FETCH;
          end else begin
            done_match <= 1'b0;
            state      <= S_DONE;
          end
        end
        S_XFETCH: begin
          if (pp == plen) begin
            done_match <= 1'b1;
            state      <= S_DONE;
          end else begin
            state <= S_XEVAL;
          end
        end
        S_XEVAL: begin
          if (pa_data != c_data) begin
            done_match <= 1'b0;
            state      <= S_DONE;
          end else begin
            pp    <= pp + 1'b1;
            cp    <= cp + 1'b1;
            state <= S_XFETCH;
          end
        end
        S_DONE: begin
          res_valid   <= 1'b1;
          res_matched <= done_match && !ovf_seen;
          res_ovf     <= ovf_seen;
          plen        <= '0;
          clen        <= '0;
          ovf_seen    <= 1'b0;
          seg_v       <= 1'b0;
          span_v      <= 1'b0;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/url_glob_matcher.sv
// Top level of the url glob matcher: config registers, front queue, engine.
// Depends on ugm_pkg, ugm_front, ugm_engine and url_glob_matcher_macros.svh.
// Loads: 1 byte beat per cycle while the front queue is not full. A finish is rejected outright
// (flags, overflow, exact length), compared byte by byte in exact mode, or else run through glob
// steps with star run ends, segment retries and span retries.
// Reset (rst, synchronous): both strings empty, no result waiting, flags 0, mask 1.
`include "url_glob_matcher_macros.svh"

module url_glob_matcher (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] op,
  input  logic [7:0] byte_value,
  output logic       empty,
  input  logic       pop,
  output logic       matched,
  output logic       overflow,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data
);

  logic [1:0]           match_flags;
  logic [1:0]           known_flags_mask;
  ugm_pkg::fq_out_t     fq;
  ugm_pkg::eng_status_t eng_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_flags      <= '0;
      known_flags_mask <= ugm_pkg::KNOWN_MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ugm_pkg::REG_MATCH_FLAGS: match_flags      <= cfg_data;
        ugm_pkg::REG_KNOWN_MASK:  known_flags_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  ugm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .op         (op),
    .byte_value (byte_value),
    .fq         (fq),
    .fq_ready   (eng_status.ready)
  );

  ugm_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .fq         (fq),
    .status     (eng_status),
    .flags      (match_flags),
    .known_mask (known_flags_mask),
    .empty      (empty),
    .pop        (pop),
    .matched    (matched),
    .overflow   (overflow)
  );

  `UGM_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (empty && !full), "reset left queues busy")
  `UGM_ASSERT(a_ovf_no_match, clk, rst, (!empty && overflow) |-> !matched, "match with overflow")
  `UGM_ASSERT(a_busy_stalls, clk, rst, eng_status.busy |-> !eng_status.ready, "engine took item while busy")
  `UGM_ASSERT(a_finish_slot, clk, rst, (fq.valid && eng_status.ready && fq.item.kind == ugm_pkg::KIND_FINISH) |-> empty, "finish taken with result pending")

endmodule
